>>> rtl/utrb_pkg.sv
// shared types and constants for the uart transmit/receive ring buffers
// no dependencies; imported by the top level
package utrb_pkg;

    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_IDX_W = $clog2(TX_DEPTH);
    localparam int RX_IDX_W = $clog2(RX_DEPTH);
    localparam int RX_CNT_W = RX_IDX_W + 1;

    localparam int BYTE_W   = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_TX_READY = 2'd1,
        FUNC_RX_LINE  = 2'd2,
        FUNC_READ     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FRAME   = 3'd1,
        ST_OVERRUN = 3'd2,
        ST_PARITY  = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    // frame beats overrun beats parity
    function automatic status_t rank_status(input logic fe, input logic ov, input logic pe);
        status_t st;
        priority if (fe)
            st = ST_FRAME;
        else if (ov)
            st = ST_OVERRUN;
        else if (pe)
            st = ST_PARITY;
        else
            st = ST_OK;
        return st;
    endfunction

endpackage

>>> rtl/utrb_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module utrb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/uart_tx_rx_ring_buffers.sv
// top level: transmit and receive ring buffers of one uart port
// depends on utrb_pkg and utrb_ram
//
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------------------
// command   | in        | start & !busy          | func, data_byte, frame_err, overrun_err,
//           |           |                        | parity_err
// result    | out       | done, one cycle only   | push_accepted, line_byte, line_valid,
//           |           |                        | tx_irq_on, read_byte, read_valid,
//           |           |                        | rx_status, rx_count
//
// one word is taken every cycle; busy is always low
// the result of a word shows up with done in the cycle right after it is taken,
// since the read port of each ring ram is registered
// reset clears the ring indices, the transmit interrupt enable and the status;
// the ring contents need no clearing, pops only reach written slots
// the receiver cannot stall: done is a strobe and results are not held
module uart_tx_rx_ring_buffers (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [utrb_pkg::FUNC_W-1:0]     func,
    input  logic [utrb_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            frame_err,
    input  logic                            overrun_err,
    input  logic                            parity_err,
    output logic                            done,
    output logic                            push_accepted,
    output logic [utrb_pkg::BYTE_W-1:0]     line_byte,
    output logic                            line_valid,
    output logic                            tx_irq_on,
    output logic [utrb_pkg::BYTE_W-1:0]     read_byte,
    output logic                            read_valid,
    output logic [utrb_pkg::STATUS_W-1:0]   rx_status,
    output logic [utrb_pkg::COUNT_W-1:0]    rx_count
);

    import utrb_pkg::*;

    // ring indices: head is the last written slot, tail the last popped slot
    logic [TX_IDX_W-1:0] tx_head_reg, tx_head_next;
    logic [TX_IDX_W-1:0] tx_tail_reg, tx_tail_next;
    logic [RX_IDX_W-1:0] rx_head_reg, rx_head_next;
    logic [RX_IDX_W-1:0] rx_tail_reg, rx_tail_next;
    status_t             status_reg, status_next;
    logic                tx_irq_reg, tx_irq_next;

    // result registers, shown with done in the cycle after the word is taken
    logic                done_reg;
    logic                push_acc_reg, push_acc_next;
    logic                line_valid_reg, line_valid_next;
    logic                read_valid_reg, read_valid_next;
    logic [COUNT_W-1:0]  rx_count_reg, rx_count_next;

    logic                accept;
    func_t               func_in;

    // wrapped increments, written as a compare so any depth works
    logic [TX_IDX_W-1:0] tx_head_inc, tx_tail_inc;
    logic [RX_IDX_W-1:0] rx_head_inc, rx_tail_inc;
    logic                tx_empty;
    logic [RX_CNT_W-1:0] rx_fill;

    // ram controls
    logic                tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0]   tx_rdata, rx_rdata;

    assign accept  = start && !busy;
    assign busy    = 1'b0;
    assign func_in = func_t'(func);

    assign tx_head_inc = (tx_head_reg == TX_IDX_W'(TX_DEPTH - 1)) ? '0
                                                                   : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_IDX_W'(TX_DEPTH - 1)) ? '0
                                                                   : tx_tail_reg + 1'b1;
    assign rx_head_inc = (rx_head_reg == RX_IDX_W'(RX_DEPTH - 1)) ? '0
                                                                   : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_IDX_W'(RX_DEPTH - 1)) ? '0
                                                                   : rx_tail_reg + 1'b1;

    assign tx_empty = (tx_head_reg == tx_tail_reg);

    // receive fill level, (head - tail) mod depth
    always_comb
    begin
        if (rx_head_reg >= rx_tail_reg)
            rx_fill = {1'b0, rx_head_reg} - {1'b0, rx_tail_reg};
        else
            rx_fill = {1'b0, rx_head_reg} + RX_CNT_W'(RX_DEPTH) - {1'b0, rx_tail_reg};
    end

    // event decode: each word touches at most one ring and one ram port
    always_comb
    begin
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        status_next     = status_reg;
        tx_irq_next     = tx_irq_reg;
        push_acc_next   = 1'b0;
        line_valid_next = 1'b0;
        read_valid_next = 1'b0;
        rx_count_next   = '0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        if (accept)
        begin
            unique case (func_in)
                FUNC_PUSH:
                begin
                    // interrupt enabled even when the push is refused
                    tx_irq_next = 1'b1;
                    if (tx_head_inc != tx_tail_reg)
                    begin
                        tx_we         = 1'b1;
                        tx_head_next  = tx_head_inc;
                        push_acc_next = 1'b1;
                    end
                end
                FUNC_TX_READY:
                begin
                    if (!tx_empty)
                    begin
                        tx_re           = 1'b1;
                        tx_tail_next    = tx_tail_inc;
                        line_valid_next = 1'b1;
                    end
                    else
                    begin
                        tx_irq_next = 1'b0;
                    end
                end
                FUNC_RX_LINE:
                begin
                    // full queue drops the byte and flags overrun
                    if (rx_head_inc == rx_tail_reg)
                    begin
                        status_next = ST_OVERRUN;
                    end
                    else
                    begin
                        rx_we        = 1'b1;
                        rx_head_next = rx_head_inc;
                        status_next  = rank_status(frame_err, overrun_err, parity_err);
                    end
                end
                FUNC_READ:
                begin
                    rx_count_next = COUNT_W'(rx_fill);
                    if (rx_fill != '0)
                    begin
                        rx_re           = 1'b1;
                        rx_tail_next    = rx_tail_inc;
                        read_valid_next = 1'b1;
                        status_next     = rank_status(frame_err, overrun_err, parity_err);
                    end
                    else
                    begin
                        // empty read times out at once
                        status_next = ST_TIMEOUT;
                    end
                end
                default:
                begin
                    tx_irq_next = tx_irq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            status_reg     <= ST_OK;
            tx_irq_reg     <= 1'b0;
            done_reg       <= 1'b0;
            push_acc_reg   <= 1'b0;
            line_valid_reg <= 1'b0;
            read_valid_reg <= 1'b0;
            rx_count_reg   <= '0;
        end
        else
        begin
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            status_reg     <= status_next;
            tx_irq_reg     <= tx_irq_next;
            done_reg       <= accept;
            push_acc_reg   <= push_acc_next;
            line_valid_reg <= line_valid_next;
            read_valid_reg <= read_valid_next;
            rx_count_reg   <= rx_count_next;
        end
    end

    // push writes the slot after head, pop reads the slot after tail;
    // a word never does both on one ring, so no forwarding is needed
    utrb_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_inc),
        .wdata (data_byte),
        .re    (tx_re),
        .raddr (tx_tail_inc),
        .rdata (tx_rdata)
    );

    utrb_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_inc),
        .wdata (data_byte),
        .re    (rx_re),
        .raddr (rx_tail_inc),
        .rdata (rx_rdata)
    );

    assign done          = done_reg;
    assign push_accepted = push_acc_reg;
    assign line_valid    = line_valid_reg;
    assign line_byte     = line_valid_reg ? tx_rdata : '0;
    assign read_valid    = read_valid_reg;
    assign read_byte     = read_valid_reg ? rx_rdata : '0;
    assign tx_irq_on     = tx_irq_reg;
    assign rx_status     = status_reg;
    assign rx_count      = rx_count_reg;

`ifndef SYNTHESIS
    // a result carries at most one of push, transmit and read data
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({push_acc_reg, line_valid_reg, read_valid_reg}))
        else $error("result flags more than one event kind");

    // a pop from a non-empty transmit ring always sends a byte
    a_tx_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func_in == FUNC_TX_READY && !tx_empty) |=> (done_reg && line_valid_reg))
        else $error("transmit pop lost its byte");

    // a push always leaves the transmit interrupt enabled
    a_push_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func_in == FUNC_PUSH) |=> tx_irq_reg)
        else $error("push did not enable transmit interrupt");

    // a valid read reports a non-zero fill and a status other than timeout
    a_read_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && read_valid_reg) |-> (rx_count_reg != '0 && status_reg != ST_TIMEOUT))
        else $error("valid read with empty receive ring");

    // receive ring never reports more bytes than it can hold
    a_rx_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill < RX_CNT_W'(RX_DEPTH))
        else $error("receive fill out of range");
`endif

endmodule
